@@ hw/rtl/dgrp_pkg.sv @@
// Shared types, constants and the 3x5 digit font for the glyph row packer.
package dgrp_pkg;

    // Input field widths
    localparam int COL_W   = 3;
    localparam int TOP_W   = 6;
    localparam int VALUE_W = 14;

    // Output field widths
    localparam int RAM_COL_W = 4;
    localparam int RAM_ROW_W = 5;
    localparam int WORD_W    = 16;

    // Digit coding and value limits
    localparam logic [3:0]         BLANK_GLYPH = 4'd10;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 14'd9999;
    localparam logic [2:0]         FONT_ROWS   = 3'd5;
    localparam int                 REM1_W      = 10;  // remainder below 1000
    localparam int                 REM2_W      = 7;   // remainder below 100

    // Queue between the digit splitter and the row emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // 3x5 font, digits 0..9 then blank; row 0 sits in bits 19:16
    localparam logic [19:0] FONT_ROM [0:10] = '{
        20'heaaae, 20'h44444, 20'he2e8e, 20'he2e2e, 20'haae22,
        20'he8e2e, 20'he8eae, 20'he2222, 20'heaeae, 20'heae22,
        20'h00000
    };

    // Item after the first split stage: thousands done
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [TOP_W-1:0]  top;
        logic [3:0]        d0;
        logic [REM1_W-1:0] rem;
    } t_split;

    // Fully classified item: four glyph codes plus placement
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [TOP_W-1:0] top;
        logic [3:0]       d0;
        logic [3:0]       d1;
        logic [3:0]       d2;
        logic [3:0]       d3;
    } t_item;

    // One nibble of a glyph row; codes past blank and rows past the font read as zero
    function automatic logic [3:0] font_nibble(input logic [3:0] glyph, input logic [2:0] row);
        logic [19:0] g;
        logic [3:0]  nib;
        g = '0;
        if (glyph <= BLANK_GLYPH) begin
            g = FONT_ROM[glyph];
        end
        case (row)
            3'd0:    nib = g[19:16];
            3'd1:    nib = g[15:12];
            3'd2:    nib = g[11:8];
            3'd3:    nib = g[7:4];
            3'd4:    nib = g[3:0];
            default: nib = 4'd0;
        endcase
        return nib;
    endfunction

endpackage

@@ hw/rtl/dgrp_front.sv @@
// Front end: accept a request, clamp the value and split it into four glyph codes.
module dgrp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dgrp_pkg::COL_W-1:0]   i_word_column,
    input  logic [dgrp_pkg::TOP_W-1:0]   i_top_row,
    input  logic [dgrp_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output dgrp_pkg::t_item              o_item
);
    import dgrp_pkg::*;

    logic                r_s1_v;
    t_split              r_s1;
    logic                r_s2_v;
    t_item               r_s2;
    logic                s1_adv;
    logic                s2_adv;
    logic [VALUE_W-1:0]  clamped;
    logic [3:0]          thou;
    t_split              n_s1;
    logic [3:0]          hund;
    logic [REM2_W-1:0]   rem2;
    logic [3:0]          tens;
    logic [3:0]          units;
    t_item               n_s2;

    // Advance each stage when the one after it can take its contents
    assign s2_adv  = !r_s2_v || i_ready;
    assign s1_adv  = !r_s1_v || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_s2_v;
    assign o_item  = r_s2;

    // Stage 1: saturate, then thousands by parallel compares against multiples of 1000
    always_comb begin
        clamped = (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
        thou    = 4'd0;
        n_s1.rem = clamped[REM1_W-1:0];
        for (int k = 1; k <= 9; k++) begin
            if (clamped >= VALUE_W'(k * 1000)) begin
                thou     = 4'(k);
                n_s1.rem = REM1_W'(clamped - VALUE_W'(k * 1000));
            end
        end
        n_s1.col = i_word_column;
        n_s1.top = i_top_row;
        // Blank the leading digit below one thousand
        n_s1.d0  = (thou == 4'd0) ? BLANK_GLYPH : thou;
    end

    // Stage 2: hundreds from the remainder below 1000, then tens and units
    always_comb begin
        hund = 4'd0;
        rem2 = r_s1.rem[REM2_W-1:0];
        for (int k = 1; k <= 9; k++) begin
            if (r_s1.rem >= REM1_W'(k * 100)) begin
                hund = 4'(k);
                rem2 = REM2_W'(r_s1.rem - REM1_W'(k * 100));
            end
        end
        tens  = 4'd0;
        units = rem2[3:0];
        for (int k = 1; k <= 9; k++) begin
            if (rem2 >= REM2_W'(k * 10)) begin
                tens  = 4'(k);
                units = 4'(rem2 - REM2_W'(k * 10));
            end
        end
        n_s2.col = r_s1.col;
        n_s2.top = r_s1.top;
        n_s2.d0  = r_s1.d0;
        n_s2.d1  = hund;
        n_s2.d2  = tens;
        n_s2.d3  = units;
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= i_valid;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_s1 <= n_s1;
        end
        if (s2_adv && r_s1_v) begin
            r_s2 <= n_s2;
        end
    end

endmodule

@@ hw/rtl/dgrp_queue.sv @@
// Short queue of classified requests between the front end and the row emitter.
module dgrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  dgrp_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output dgrp_pkg::t_item o_pop_item
);
    import dgrp_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   push;
    logic                   pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level past depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill level");

endmodule

@@ hw/rtl/dgrp_back.sv @@
// Back end: walk the glyph rows of the head request and emit one packed word per row.
module dgrp_back #(
    parameter int GLYPH_ROWS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  dgrp_pkg::t_item                i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dgrp_pkg::RAM_COL_W-1:0] o_ram_column,
    output logic [dgrp_pkg::RAM_ROW_W-1:0] o_ram_row,
    output logic [dgrp_pkg::WORD_W-1:0]    o_pixel_word,
    output logic                           o_last_row
);
    import dgrp_pkg::*;

    localparam int ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

    logic [ROW_W-1:0]     r_row;
    logic                 r_o_valid;
    logic [RAM_COL_W-1:0] r_ram_column;
    logic [RAM_ROW_W-1:0] r_ram_row;
    logic [WORD_W-1:0]    r_pixel_word;
    logic                 r_last_row;
    logic                 load;
    logic                 last;
    logic [TOP_W-1:0]     row_sum;
    logic [2:0]           font_row;
    logic [RAM_COL_W-1:0] n_ram_column;
    logic [RAM_ROW_W-1:0] n_ram_row;
    logic [WORD_W-1:0]    n_pixel_word;

    // Load the output register when a request is waiting and the register is empty or being drained
    assign load    = i_valid && (!r_o_valid || i_ready);
    assign last    = (r_row == ROW_W'(GLYPH_ROWS - 1));
    assign o_ready = load && last;

    // Fold rows 32..63 onto the right half of the controller's address space
    always_comb begin
        row_sum      = i_item.top + TOP_W'(r_row);
        font_row     = 3'(r_row);
        n_ram_row    = row_sum[RAM_ROW_W-1:0];
        n_ram_column = {row_sum[TOP_W-1], i_item.col};
        n_pixel_word = {font_nibble(i_item.d0, font_row), font_nibble(i_item.d1, font_row),
                        font_nibble(i_item.d2, font_row), font_nibble(i_item.d3, font_row)};
    end

    // Row counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_row     <= last ? '0 : r_row + 1'b1;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ram_column <= n_ram_column;
            r_ram_row    <= n_ram_row;
            r_pixel_word <= n_pixel_word;
            r_last_row   <= last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_ram_column = r_ram_column;
    assign o_ram_row    = r_ram_row;
    assign o_pixel_word = r_pixel_word;
    assign o_last_row   = r_last_row;

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(GLYPH_ROWS - 1))
        else $error("row counter past last glyph row");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && last) |=> (r_row == '0 && r_last_row))
        else $error("row counter did not restart after last row");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !last) |=> (r_row == $past(r_row) + 1'b1 && !r_last_row))
        else $error("row counter did not advance by one");

endmodule

@@ hw/rtl/decimal_digit_glyph_row_packer.sv @@
// Top level of the decimal glyph row packer: front end, queue and row emitter.
// Each accepted request (word column, top pixel row, value) produces GLYPH_ROWS
// result words, top row first, with last_row set on the final one. Values above
// 9999 show as 9999 and the thousands position is blank below 1000. Rows are
// taken modulo 64 and rows 32..63 are folded to rows 0..31 with the word column
// plus 8. The row emitter issues one word per cycle while a request is waiting
// and the result port is ready, so a request occupies the port for GLYPH_ROWS
// words, and it takes the next request only once the last row of the current
// one is loaded. A request passes through the first digit-split stage, the
// second stage, the queue and the output register in that order. The front end
// keeps taking requests while the emitter works, until its stages and the
// two-entry queue are full.
module decimal_digit_glyph_row_packer #(
    parameter int GLYPH_ROWS = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dgrp_pkg::COL_W-1:0]     i_word_column,
    input  logic [dgrp_pkg::TOP_W-1:0]     i_top_row,
    input  logic [dgrp_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dgrp_pkg::RAM_COL_W-1:0] o_ram_column,
    output logic [dgrp_pkg::RAM_ROW_W-1:0] o_ram_row,
    output logic [dgrp_pkg::WORD_W-1:0]    o_pixel_word,
    output logic                           o_last_row
);
    import dgrp_pkg::*;

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  head_valid;
    logic  head_ready;
    t_item head_item;

    // Accept and classify requests
    dgrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_word_column (i_word_column),
        .i_top_row     (i_top_row),
        .i_value       (i_value),
        .o_valid       (front_valid),
        .i_ready       (front_ready),
        .o_item        (front_item)
    );

    // Decouple the two sides
    dgrp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (head_valid),
        .i_pop_ready  (head_ready),
        .o_pop_item   (head_item)
    );

    // Emit the row words
    dgrp_back #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .o_ready      (head_ready),
        .i_item       (head_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ram_column (o_ram_column),
        .o_ram_row    (o_ram_row),
        .o_pixel_word (o_pixel_word),
        .o_last_row   (o_last_row)
    );

endmodule
